@@ hdl/ecfd_pkg.sv @@
package ecfd_pkg;

    // Output queue geometry
    localparam int QDepth   = 8;
    localparam int QAddrW   = $clog2(QDepth);
    localparam int QCountW  = QAddrW + 1;
    // Input side holds off while this many or more results are queued
    localparam int QHighMark = QDepth - 4;

    localparam logic [7:0] MaxDatagramsReset = 8'd200;

    // Result kinds
    localparam logic [1:0] KIND_HEADER   = 2'd0;
    localparam logic [1:0] KIND_DATA     = 2'd1;
    localparam logic [1:0] KIND_DATAGRAM = 2'd2;
    localparam logic [1:0] KIND_SUMMARY  = 2'd3;

    // Stop codes
    localparam logic [2:0] STOP_CHAIN_END  = 3'd0;
    localparam logic [2:0] STOP_HDR_CUT    = 3'd1;
    localparam logic [2:0] STOP_DATA_CUT   = 3'd2;
    localparam logic [2:0] STOP_MORE_EMPTY = 3'd3;
    localparam logic [2:0] STOP_CAP        = 3'd4;
    localparam logic [2:0] STOP_NOT_ECAT   = 3'd5;
    localparam logic [2:0] STOP_NON_CMD    = 3'd6;

    localparam logic [3:0] TYPE_COMMAND  = 4'd1;
    localparam logic [3:0] TYPE_LAST_OK  = 4'd5;
    localparam logic [3:0] DG_HDR_LAST   = 4'd9;

    localparam logic [7:0] CMD_LRD = 8'd10;
    localparam logic [7:0] CMD_LWR = 8'd11;
    localparam logic [7:0] CMD_LRW = 8'd12;

    typedef enum logic [6:0] {
        PH_HDR0    = 7'b0000001,
        PH_HDR1    = 7'b0000010,
        PH_DGHDR   = 7'b0000100,
        PH_DATA    = 7'b0001000,
        PH_WKC     = 7'b0010000,
        PH_STOPPED = 7'b0100000,
        PH_IGNORE  = 7'b1000000
    } t_phase;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  ecat_type;
        logic [7:0]  command;
        logic [7:0]  datagram_index;
        logic        logical_mode;
        logic [31:0] address_word;
        logic [10:0] length_field;
        logic [3:0]  flag_bits;
        logic [15:0] irq_word;
        logic [15:0] value_word;
        logic [2:0]  stop_status;
        logic        last_result;
    } t_result;

    // Up to two results per input item, in order r0 then r1
    typedef struct packed {
        logic [1:0] cnt;
        t_result    r0;
        t_result    r1;
    } t_push;

    function automatic t_result blank_result(input logic [3:0] ftype);
        t_result r;
        r = '0;
        r.ecat_type = ftype;
        return r;
    endfunction

    function automatic logic is_logical(input logic [7:0] cmd);
        return cmd inside {CMD_LRD, CMD_LWR, CMD_LRW};
    endfunction

endpackage

@@ hdl/ecfd_parser.sv @@
module ecfd_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [7:0]          i_byte,
    input  logic                i_last,
    input  logic [7:0]          i_max_datagrams,
    output ecfd_pkg::t_push     o_push
);

    ecfd_pkg::t_phase r_phase, n_phase;
    logic [3:0]  r_pos, n_pos;
    logic [7:0]  r_hdr_lo, n_hdr_lo;
    logic [10:0] r_decl, n_decl;
    logic [15:0] r_consumed, n_consumed;
    logic        r_resv, n_resv;
    logic [7:0]  r_cmd, n_cmd;
    logic [7:0]  r_idx, n_idx;
    logic [31:0] r_addr, n_addr;
    logic [15:0] r_lenw, n_lenw;
    logic [15:0] r_irq, n_irq;
    logic [10:0] r_left, n_left;
    logic [7:0]  r_wkc_lo, n_wkc_lo;
    logic [7:0]  r_count, n_count;
    logic [2:0]  r_stop, n_stop;
    logic [3:0]  r_ftype, n_ftype;
    logic [15:0] r_run, n_run;

    ecfd_pkg::t_result step_r, sum_r;
    logic step_v;

    function automatic ecfd_pkg::t_result fill_dg(
        input logic [3:0]  ftype,
        input logic [7:0]  cmd,
        input logic [7:0]  idx,
        input logic [31:0] addr,
        input logic [15:0] lenw,
        input logic [15:0] irq
    );
        ecfd_pkg::t_result r;
        r = ecfd_pkg::blank_result(ftype);
        r.command        = cmd;
        r.datagram_index = idx;
        r.logical_mode   = ecfd_pkg::is_logical(cmd);
        r.address_word   = addr;
        r.length_field   = lenw[10:0];
        r.flag_bits      = {2'b00, lenw[15], lenw[14]};
        r.irq_word       = irq;
        return r;
    endfunction

    always_comb begin
        logic        in_region;
        logic        region_done;
        logic [15:0] hdr_word;
        logic [3:0]  ftype;
        logic [15:0] run_inc;
        logic [2:0]  st;

        n_phase    = r_phase;
        n_pos      = r_pos;
        n_hdr_lo   = r_hdr_lo;
        n_decl     = r_decl;
        n_consumed = r_consumed;
        n_resv     = r_resv;
        n_cmd      = r_cmd;
        n_idx      = r_idx;
        n_addr     = r_addr;
        n_lenw     = r_lenw;
        n_irq      = r_irq;
        n_left     = r_left;
        n_wkc_lo   = r_wkc_lo;
        n_count    = r_count;
        n_stop     = r_stop;
        n_ftype    = r_ftype;
        n_run      = r_run;
        step_v     = 1'b0;
        step_r     = ecfd_pkg::blank_result(r_ftype);
        sum_r      = '0;
        region_done = 1'b0;
        st          = ecfd_pkg::STOP_CHAIN_END;

        in_region = (r_decl == 11'd0) || (r_consumed < {5'd0, r_decl});
        hdr_word  = {i_byte, r_hdr_lo};
        ftype     = i_byte[7:4];
        run_inc   = (r_run != 16'hFFFF) ? r_run + 16'd1 : r_run;

        case (r_phase)
            ecfd_pkg::PH_HDR0: begin
                n_hdr_lo = i_byte;
                n_ftype  = 4'd0;
                n_phase  = ecfd_pkg::PH_HDR1;
            end
            ecfd_pkg::PH_HDR1: begin
                n_decl     = hdr_word[10:0];
                n_resv     = hdr_word[11];
                n_ftype    = ftype;
                n_consumed = 16'd0;
                n_count    = 8'd0;
                n_run      = 16'd0;
                n_stop     = ecfd_pkg::STOP_CHAIN_END;
                n_pos      = 4'd0;
                if (ftype == 4'd0 || ftype > ecfd_pkg::TYPE_LAST_OK) begin
                    n_stop  = ecfd_pkg::STOP_NOT_ECAT;
                    n_phase = ecfd_pkg::PH_IGNORE;
                end else begin
                    step_v              = 1'b1;
                    step_r              = ecfd_pkg::blank_result(ftype);
                    step_r.kind         = ecfd_pkg::KIND_HEADER;
                    step_r.length_field = hdr_word[10:0];
                    if (ftype != ecfd_pkg::TYPE_COMMAND) begin
                        n_stop  = ecfd_pkg::STOP_NON_CMD;
                        n_phase = ecfd_pkg::PH_IGNORE;
                    end else if (i_max_datagrams == 8'd0) begin
                        n_stop  = ecfd_pkg::STOP_CAP;
                        n_phase = ecfd_pkg::PH_STOPPED;
                    end else begin
                        n_phase = ecfd_pkg::PH_DGHDR;
                    end
                end
            end
            ecfd_pkg::PH_DGHDR, ecfd_pkg::PH_DATA, ecfd_pkg::PH_WKC,
            ecfd_pkg::PH_STOPPED, ecfd_pkg::PH_IGNORE: begin
                if (r_consumed != 16'hFFFF) begin
                    n_consumed = r_consumed + 16'd1;
                end
                if (in_region) begin
                    case (r_phase)
                        ecfd_pkg::PH_DGHDR: begin
                            n_run = run_inc;
                            case (r_pos)
                                4'd0: n_cmd = i_byte;
                                4'd1: n_idx = i_byte;
                                4'd2: n_addr = {24'd0, i_byte};
                                4'd3: n_addr[15:8] = i_byte;
                                4'd4: n_addr[23:16] = i_byte;
                                4'd5: n_addr[31:24] = i_byte;
                                4'd6: n_lenw = {8'd0, i_byte};
                                4'd7: n_lenw[15:8] = i_byte;
                                4'd8: n_irq = {8'd0, i_byte};
                                default: n_irq[15:8] = i_byte;
                            endcase
                            if (r_pos >= ecfd_pkg::DG_HDR_LAST) begin
                                n_left  = r_lenw[10:0];
                                n_run   = 16'd0;
                                n_pos   = 4'd0;
                                n_phase = (r_lenw[10:0] != 11'd0) ? ecfd_pkg::PH_DATA
                                                                   : ecfd_pkg::PH_WKC;
                            end else begin
                                n_pos = r_pos + 4'd1;
                            end
                        end
                        ecfd_pkg::PH_DATA: begin
                            n_run            = run_inc;
                            step_v           = 1'b1;
                            step_r           = fill_dg(r_ftype, r_cmd, r_idx, r_addr,
                                                       r_lenw, r_irq);
                            step_r.kind      = ecfd_pkg::KIND_DATA;
                            step_r.flag_bits = 4'd0;
                            step_r.value_word = {8'd0, i_byte};
                            if (r_left != 11'd0) begin
                                n_left = r_left - 11'd1;
                            end
                            if (n_left == 11'd0) begin
                                n_pos   = 4'd0;
                                n_phase = ecfd_pkg::PH_WKC;
                            end
                        end
                        ecfd_pkg::PH_WKC: begin
                            n_run = run_inc;
                            if (r_pos == 4'd0) begin
                                n_wkc_lo = i_byte;
                                n_pos    = 4'd1;
                            end else begin
                                region_done = i_last ||
                                    ((r_decl != 11'd0) && (n_consumed >= {5'd0, r_decl}));
                                if (r_count != 8'hFF) begin
                                    n_count = r_count + 8'd1;
                                end
                                step_v            = 1'b1;
                                step_r            = fill_dg(r_ftype, r_cmd, r_idx, r_addr,
                                                            r_lenw, r_irq);
                                step_r.kind       = ecfd_pkg::KIND_DATAGRAM;
                                step_r.value_word = {i_byte, r_wkc_lo};
                                n_run = 16'd0;
                                n_pos = 4'd0;
                                if (!r_lenw[15]) begin
                                    n_stop  = ecfd_pkg::STOP_CHAIN_END;
                                    n_phase = ecfd_pkg::PH_STOPPED;
                                end else if (region_done) begin
                                    n_stop  = ecfd_pkg::STOP_MORE_EMPTY;
                                    n_phase = ecfd_pkg::PH_STOPPED;
                                end else if (n_count >= i_max_datagrams) begin
                                    n_stop  = ecfd_pkg::STOP_CAP;
                                    n_phase = ecfd_pkg::PH_STOPPED;
                                end else begin
                                    n_phase = ecfd_pkg::PH_DGHDR;
                                end
                            end
                        end
                        ecfd_pkg::PH_STOPPED: begin
                            n_run = run_inc;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                n_phase = ecfd_pkg::PH_HDR0;
            end
        endcase

        // End summary, built from the state after this byte
        case (n_phase)
            ecfd_pkg::PH_HDR1:              st = ecfd_pkg::STOP_NOT_ECAT;
            ecfd_pkg::PH_DGHDR:             st = ecfd_pkg::STOP_HDR_CUT;
            ecfd_pkg::PH_DATA,
            ecfd_pkg::PH_WKC:               st = ecfd_pkg::STOP_DATA_CUT;
            default:                        st = n_stop;
        endcase
        sum_r             = ecfd_pkg::blank_result(n_ftype);
        sum_r.kind        = ecfd_pkg::KIND_SUMMARY;
        sum_r.stop_status = st;
        sum_r.last_result = 1'b1;
        if (st != ecfd_pkg::STOP_NOT_ECAT) begin
            sum_r.flag_bits[1] = n_resv;
            if (st != ecfd_pkg::STOP_NON_CMD) begin
                sum_r.flag_bits[0] = (n_decl == 11'd0) || (n_consumed < {5'd0, n_decl});
                sum_r.value_word   = n_run;
            end
        end
        if (i_last) begin
            n_phase = ecfd_pkg::PH_HDR0;
        end
    end

    always_comb begin
        o_push = '0;
        if (i_valid) begin
            if (step_v) begin
                o_push.r0  = step_r;
                o_push.r1  = sum_r;
                o_push.cnt = i_last ? 2'd2 : 2'd1;
            end else if (i_last) begin
                o_push.r0  = sum_r;
                o_push.cnt = 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= ecfd_pkg::PH_HDR0;
            r_pos      <= '0;
            r_hdr_lo   <= '0;
            r_decl     <= '0;
            r_consumed <= '0;
            r_resv     <= 1'b0;
            r_cmd      <= '0;
            r_idx      <= '0;
            r_addr     <= '0;
            r_lenw     <= '0;
            r_irq      <= '0;
            r_left     <= '0;
            r_wkc_lo   <= '0;
            r_count    <= '0;
            r_stop     <= '0;
            r_ftype    <= '0;
            r_run      <= '0;
        end else if (i_valid) begin
            r_phase    <= n_phase;
            r_pos      <= n_pos;
            r_hdr_lo   <= n_hdr_lo;
            r_decl     <= n_decl;
            r_consumed <= n_consumed;
            r_resv     <= n_resv;
            r_cmd      <= n_cmd;
            r_idx      <= n_idx;
            r_addr     <= n_addr;
            r_lenw     <= n_lenw;
            r_irq      <= n_irq;
            r_left     <= n_left;
            r_wkc_lo   <= n_wkc_lo;
            r_count    <= n_count;
            r_stop     <= n_stop;
            r_ftype    <= n_ftype;
            r_run      <= n_run;
        end
    end

endmodule

@@ hdl/ecfd_queue.sv @@
module ecfd_queue (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ecfd_pkg::t_push               i_push,
    input  logic                          i_pop,
    output logic                          o_valid,
    output ecfd_pkg::t_result             o_head,
    output logic [ecfd_pkg::QCountW-1:0]  o_count
);

    ecfd_pkg::t_result r_mem [ecfd_pkg::QDepth];
    logic [ecfd_pkg::QAddrW-1:0]  r_wp, n_wp;
    logic [ecfd_pkg::QAddrW-1:0]  r_rp, n_rp;
    logic [ecfd_pkg::QCountW-1:0] r_count, n_count;
    logic [ecfd_pkg::QAddrW-1:0]  wp_next;

    assign wp_next = r_wp + ecfd_pkg::QAddrW'(1);
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rp];
    assign o_count = r_count;

    always_comb begin
        n_wp    = r_wp + ecfd_pkg::QAddrW'(i_push.cnt);
        n_rp    = i_pop ? r_rp + ecfd_pkg::QAddrW'(1) : r_rp;
        n_count = r_count + ecfd_pkg::QCountW'(i_push.cnt)
                - ecfd_pkg::QCountW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wp] <= i_push.r0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[wp_next] <= i_push.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

endmodule

@@ hdl/ethercat_frame_deframer.sv @@
// Channel   Direction  Handshake          Payload
// input     in         i_valid / o_stall  i_payload_byte, i_end_of_payload
// result    out        o_valid / i_stall  o_kind ... o_last_result (12 fields)
// config    in         i_cfg_wr_en        i_cfg_wr_data (max_datagrams)
//
// One payload byte per clock while o_stall is low. An accepted byte passes the input
// register, then the parser writes its results into the output queue.
// A byte yields at most two results (its own and the end summary), queued 8 deep;
// o_stall rises when 4 or more results are waiting.
// Reset (synchronous, i_rst_n low) clears parser state and queue; max_datagrams
// returns to 200. No clearing pass.
module ethercat_frame_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input item
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_payload_byte,
    input  logic        i_end_of_payload,
    // configuration
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,
    // result item
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [3:0]  o_ecat_type,
    output logic [7:0]  o_command,
    output logic [7:0]  o_datagram_index,
    output logic        o_logical_mode,
    output logic [31:0] o_address_word,
    output logic [10:0] o_length_field,
    output logic [3:0]  o_flag_bits,
    output logic [15:0] o_irq_word,
    output logic [15:0] o_value_word,
    output logic [2:0]  o_stop_status,
    output logic        o_last_result
);

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    logic [7:0]  r_max_datagrams;

    logic                         in_accept;
    logic                         pop;
    ecfd_pkg::t_push              push;
    ecfd_pkg::t_result            head;
    logic [ecfd_pkg::QCountW-1:0] q_count;

    // Hold off while the queue is near full: one item in the input register plus
    // one accepted now can add four more results.
    assign o_stall   = (q_count >= ecfd_pkg::QCountW'(ecfd_pkg::QHighMark));
    assign in_accept = i_valid && !o_stall;
    assign pop       = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_max_datagrams <= ecfd_pkg::MaxDatagramsReset;
        end else begin
            r_in_valid <= in_accept;
            if (i_cfg_wr_en) begin
                r_max_datagrams <= i_cfg_wr_data;
            end
        end
    end

    // Payload register, loaded only on accept
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_payload_byte;
            r_in_last <= i_end_of_payload;
        end
    end

    ecfd_parser u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (r_in_valid),
        .i_byte          (r_in_byte),
        .i_last          (r_in_last),
        .i_max_datagrams (r_max_datagrams),
        .o_push          (push)
    );

    ecfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_valid (o_valid),
        .o_head  (head),
        .o_count (q_count)
    );

    assign o_kind           = head.kind;
    assign o_ecat_type      = head.ecat_type;
    assign o_command        = head.command;
    assign o_datagram_index = head.datagram_index;
    assign o_logical_mode   = head.logical_mode;
    assign o_address_word   = head.address_word;
    assign o_length_field   = head.length_field;
    assign o_flag_bits      = head.flag_bits;
    assign o_irq_word       = head.irq_word;
    assign o_value_word     = head.value_word;
    assign o_stop_status    = head.stop_status;
    assign o_last_result    = head.last_result;

    // Parser writes nothing without an item in the input register
    a_no_spurious_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> (push.cnt == 2'd0))
        else $error("result pushed with no item in flight");

    // Every end-of-payload byte produces a summary as its final result
    a_last_gives_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_in_last) |->
            ((push.cnt == 2'd1 && push.r0.last_result) ||
             (push.cnt == 2'd2 && push.r1.last_result && !push.r0.last_result)))
        else $error("end of payload without trailing summary");

    // Queue never overflows
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= ecfd_pkg::QCountW'(ecfd_pkg::QDepth))
        else $error("output queue overflow");

endmodule
